FILE: hw/rtl/positional_list_engine_top_macros.svh
// Assertion macros for the positional list engine.
// Included by the top level; relies on clk_i and rst_ni in the including module.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks a property on every rising clock edge outside reset.
`define PLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLE_ASSERT(label, prop, msg)
`define PLE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/ple_pkg.sv
// Shared types and constants for the positional list engine.
// No dependencies; used by the cell, the control and the top level.
`default_nettype none
package ple_pkg;

  localparam int CmdW  = 2;
  localparam int PosW  = 5;
  localparam int DataW = 32;
  localparam int LenW  = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_GET    = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } ple_cmd_e;

  // Broadcast to every cell for one accepted command.
  typedef struct packed {
    logic            ins;   // valid insert
    logic            del;   // valid delete
    logic            rd;    // valid get or delete, returns a word
    logic [PosW-1:0] slot;  // zero-based target position
  } ple_op_t;

endpackage
`default_nettype wire

FILE: hw/rtl/positional_list_engine_top.sv
// Positional list engine top level: a row of element cells plus control.
// Depends on ple_pkg, ple_cell, ple_ctrl and the assertion macro header.
//
// The engine holds an ordered list of up to DEPTH signed 32-bit words,
// numbered from 1. A command (get, insert before, delete) is taken at any
// clock edge where start is high; busy stays low, so one command can be
// issued every cycle. All cells shift in the same cycle as the command, and
// its result appears on the result ports in the following cycle for exactly
// one cycle with valid_o high. The receiver cannot stall. Bad positions,
// reserved command codes and inserts into a full list give status 1, read
// value zero, and leave the list untouched.
`default_nettype none
`include "positional_list_engine_top_macros.svh"
module positional_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ple_pkg::CmdW-1:0]   cmd_i,
  input  wire logic [ple_pkg::PosW-1:0]   position_i,
  input  wire logic [ple_pkg::DataW-1:0]  value_i,
  output logic                            valid_o,
  output logic                            status_o,
  output logic      [ple_pkg::DataW-1:0]  read_value_o,
  output logic      [ple_pkg::LenW-1:0]   length_o
);
  import ple_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic             accept;
  ple_op_t          op;
  logic             ok;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] cell_data [DEPTH];
  logic [DataW-1:0] rd_word;

  logic             valid_q, status_q;
  logic [DataW-1:0] read_value_q;
  logic [LenW-1:0]  length_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  ple_ctrl #(
    .Depth (DEPTH),
    .CntW  (CntW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .position_i (position_i),
    .op_o       (op),
    .ok_o       (ok),
    .cnt_q_o    (cnt_q),
    .cnt_d_o    (cnt_d)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = cell_data[k];
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    ple_cell #(
      .CellIdx (k)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[k])
    );
  end

  // Select the target cell; only held elements are ever returned.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (k == int'(op.slot)) begin
        rd_word = cell_data[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= !ok;
      read_value_q <= op.rd ? rd_word : '0;
      length_q     <= LenW'(cnt_d);
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign read_value_o = read_value_q;
  assign length_o     = length_q;

  `PLE_ASSERT_NEXT(a_result_follows, accept, valid_o, "accepted command gave no result")
  `PLE_ASSERT_NEXT(a_no_spurious, !accept, !valid_o, "result without a command")
  `PLE_ASSERT(a_err_zero, !(valid_o && status_o) || (read_value_o == '0), "error word nonzero")
  `PLE_ASSERT(a_err_keeps_len, !(valid_o && status_o) || (length_o == LenW'($past(cnt_q))), "error changed length")

endmodule
`default_nettype wire

FILE: hw/rtl/ple_cell.sv
// One storage cell of the list: holds one element word.
// Depends on ple_pkg for the broadcast operation type.
`default_nettype none
module ple_cell #(
  parameter int CellIdx = 0
) (
  input  wire logic                       clk_i,
  input  wire ple_pkg::ple_op_t           op_i,
  input  wire logic [ple_pkg::DataW-1:0]  value_i,
  input  wire logic [ple_pkg::DataW-1:0]  left_i,
  input  wire logic [ple_pkg::DataW-1:0]  right_i,
  output logic      [ple_pkg::DataW-1:0]  data_o
);
  import ple_pkg::*;

  logic [DataW-1:0] data_q, data_d;
  logic             at_slot, past_slot;

  assign at_slot   = (CellIdx == int'(op_i.slot));
  assign past_slot = (CellIdx >  int'(op_i.slot));

  // An insert loads the new word at the target and moves later words up;
  // a delete pulls every word from the target onward down by one.
  always_comb begin
    data_d = data_q;
    if (op_i.ins && at_slot) begin
      data_d = value_i;
    end else if (op_i.ins && past_slot) begin
      data_d = left_i;
    end else if (op_i.del && (at_slot || past_slot)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/ple_ctrl.sv
// Command decode, position checks and the element count register.
// Depends on ple_pkg for the command codes and the operation type.
`default_nettype none
module ple_ctrl #(
  parameter int Depth = 16,
  parameter int CntW  = $clog2(Depth + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      accept_i,
  input  wire logic [ple_pkg::CmdW-1:0]  cmd_i,
  input  wire logic [ple_pkg::PosW-1:0]  position_i,
  output ple_pkg::ple_op_t               op_o,
  output logic                           ok_o,
  output logic      [CntW-1:0]           cnt_q_o,
  output logic      [CntW-1:0]           cnt_d_o
);
  import ple_pkg::*;

  localparam int CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CmpW-1:0] pos_x, cnt_x;
  logic            pos_nz, in_list, ins_ok, del_ok, get_ok;

  assign pos_x   = CmpW'(position_i);
  assign cnt_x   = CmpW'(cnt_q);
  assign pos_nz  = (position_i != '0);
  assign in_list = pos_nz && (pos_x <= cnt_x);

  always_comb begin
    get_ok = 1'b0;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    unique case (ple_cmd_e'(cmd_i))
      CMD_GET: begin
        get_ok = in_list;
      end
      CMD_INSERT: begin
        ins_ok = pos_nz && (pos_x <= cnt_x + CmpW'(1)) && (cnt_x < CmpW'(Depth));
      end
      CMD_DELETE: begin
        del_ok = in_list;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    op_o.ins  = accept_i && ins_ok;
    op_o.del  = accept_i && del_ok;
    op_o.rd   = get_ok || del_ok;
    op_o.slot = position_i - PosW'(1);
    ok_o      = get_ok || ins_ok || del_ok;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (op_o.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (op_o.del) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_q_o = cnt_q;
  assign cnt_d_o = cnt_d;

endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the positional list engine: directed table, then random commands.
// Needs ple_pkg and positional_list_engine_top; every result is checked against
// a table entry or a list predictor inside this file.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int ListDepth = 16;
  localparam int IdleLimit = 2000;
  localparam int EndPause  = 8;

  localparam logic [CmdW-1:0] CmdReserved = 2'd3;
  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

  typedef struct packed {
    logic             status;
    logic [DataW-1:0] rd_word;
    logic [LenW-1:0]  len;
  } list_reply_t;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] word;
    bit               typed;
    list_reply_t      reply;
  } list_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [CmdW-1:0]  cmd_i;
  logic [PosW-1:0]  position_i;
  logic [DataW-1:0] value_i;
  logic             valid_o;
  logic             status_o;
  logic [DataW-1:0] read_value_o;
  logic [LenW-1:0]  length_o;

  // Predictor copy of the list.
  logic [DataW-1:0] held_words [ListDepth];
  int               held_len;

  list_reply_t pending_replies [$];
  list_row_t   directed_rows [$];
  int          mismatch_count;
  int          idle_cycles;

  positional_list_engine_top #(
    .DEPTH(ListDepth)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .read_value_o(read_value_o),
    .length_o    (length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic list_reply_t apply_list_op(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                                                logic [DataW-1:0] word);
    list_reply_t reply;
    int p;
    p = pos;
    reply.status  = StatusErr;
    reply.rd_word = '0;
    case (cmd)
      CMD_GET: begin
        if (p >= 1 && p <= held_len) begin
          reply.rd_word = held_words[p-1];
          reply.status  = StatusOk;
        end
      end
      CMD_INSERT: begin
        if (p >= 1 && p <= held_len + 1 && held_len < ListDepth) begin
          for (int k = held_len; k > p - 1; k--) held_words[k] = held_words[k-1];
          held_words[p-1] = word;
          held_len++;
          reply.status = StatusOk;
        end
      end
      CMD_DELETE: begin
        if (p >= 1 && p <= held_len) begin
          reply.rd_word = held_words[p-1];
          for (int k = p - 1; k + 1 < held_len; k++) held_words[k] = held_words[k+1];
          held_len--;
          reply.status = StatusOk;
        end
      end
      default: ;
    endcase
    reply.len = held_len[LenW-1:0];
    return reply;
  endfunction

  task automatic add_row(logic [CmdW-1:0] cmd, logic [PosW-1:0] pos, logic [DataW-1:0] word,
                         bit typed, logic status, logic [DataW-1:0] rd_word,
                         logic [LenW-1:0] len);
    list_row_t row;
    row.cmd           = cmd;
    row.pos           = pos;
    row.word          = word;
    row.typed         = typed;
    row.reply.status  = status;
    row.reply.rd_word = rd_word;
    row.reply.len     = len;
    directed_rows.push_back(row);
  endtask

  // Drops start for a gap, then presents one word and holds it until taken.
  task automatic send_word(int gap, logic [CmdW-1:0] cmd, logic [PosW-1:0] pos,
                           logic [DataW-1:0] word, bit typed, list_reply_t typed_reply);
    list_reply_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start      <= 1'b1;
    cmd_i      <= cmd;
    position_i <= pos;
    value_i    <= word;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_list_op(cmd, pos, word);
    pending_replies.push_back(typed ? typed_reply : predicted);
  endtask

  function automatic int draw_gap(int idle_pct);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  task automatic report_field(string field, longint expected, longint actual);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, expected, actual);
  endtask

  always @(posedge clk_i) begin
    list_reply_t want;
    if (rst_ni && valid_o) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with nothing expected, status %0d read %0d length %0d",
                 $time, status_o, $signed(read_value_o), length_o);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) report_field("status", want.status, status_o);
        if (read_value_o !== want.rd_word)
          report_field("read_value", longint'($signed(want.rd_word)),
                       longint'($signed(read_value_o)));
        if (length_o !== want.len) report_field("length", want.len, length_o);
      end
    end
  end

  // Watchdog: ends the run if neither a command nor a result moves for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((start && !busy) || valid_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    list_reply_t     no_reply;
    int              idle_pcts [3];
    int              r;
    bit              fill_bias;
    logic [CmdW-1:0] cmd;
    logic [PosW-1:0] pos;
    logic [DataW-1:0] word;

    no_reply       = '0;
    idle_pcts      = '{0, 81, 25};
    mismatch_count = 0;
    held_len       = 0;
    for (int k = 0; k < ListDepth; k++) held_words[k] = '0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    cmd_i      = CMD_GET;
    position_i = '0;
    value_i    = '0;

    // Empty list: get, delete and insert at 2 fail, then three inserts succeed.
    add_row(CMD_GET,    5'd1, 32'h0,          1, StatusErr, 32'h0, 5'd0);
    add_row(CMD_DELETE, 5'd1, 32'h0,          1, StatusErr, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd2, 32'h5,          1, StatusErr, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd1, 32'h7FFF_FFFF,  1, StatusOk,  32'h0, 5'd1);
    add_row(CMD_INSERT, 5'd1, 32'h8000_0000,  1, StatusOk,  32'h0, 5'd2);
    add_row(CMD_INSERT, 5'd3, 32'hFFFF_FFFF,  1, StatusOk,  32'h0, 5'd3);
    // Fill to capacity, alternating middle and end positions.
    add_row(CMD_INSERT, 5'd2,  32'h1234_5678, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd5,  32'hDEAD_BEEF, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd1,  32'h0000_0000, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd4,  32'hA5A5_A5A5, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd8,  32'h5A5A_5A5A, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd3,  32'h0F0F_0F0F, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd10, 32'hF0F0_F0F0, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd6,  32'h0000_0080, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd12, 32'hFFFF_FF7F, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd7,  32'h3333_CCCC, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd14, 32'hCCCC_3333, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd9,  32'h7654_3210, 0, StatusOk, 32'h0, 5'd0);
    add_row(CMD_INSERT, 5'd16, 32'h0000_0001, 0, StatusOk, 32'h0, 5'd0);
    // Full list: inserts, position 0, past-end positions and reserved codes fail.
    add_row(CMD_INSERT,  5'd1,  32'h1111_1111, 1, StatusErr, 32'h0, 5'd16);
    add_row(CMD_GET,     5'd0,  32'h0,         1, StatusErr, 32'h0, 5'd16);
    add_row(CMD_GET,     5'd17, 32'h0,         1, StatusErr, 32'h0, 5'd16);
    add_row(CmdReserved, 5'd1,  32'hFFFF_FFFF, 1, StatusErr, 32'h0, 5'd16);
    add_row(CMD_GET,     5'd16, 32'h0,         0, StatusOk,  32'h0, 5'd0);
    add_row(CMD_DELETE,  5'd17, 32'h0,         1, StatusErr, 32'h0, 5'd16);
    add_row(CMD_DELETE,  5'd16, 32'h0,         0, StatusOk,  32'h0, 5'd0);
    add_row(CMD_DELETE,  5'd1,  32'h0,         0, StatusOk,  32'h0, 5'd0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      send_word(0, directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].word,
                directed_rows[i].typed, directed_rows[i].reply);

    // Random commands, mostly at legal positions, with the mix swinging between
    // filling and draining so the list keeps crossing empty and full.
    fill_bias = 1'b1;
    foreach (idle_pcts[ph]) begin
      for (int n = 0; n < 134; n++) begin
        if (n % 20 == 0) fill_bias = ~fill_bias;
        r = $urandom_range(99);
        if (r < (fill_bias ? 55 : 25)) begin
          cmd = CMD_INSERT;
        end else if (r < (fill_bias ? 75 : 65)) begin
          cmd = CMD_DELETE;
        end else if (r < 95) begin
          cmd = CMD_GET;
        end else begin
          cmd = CmdReserved;
        end
        if ($urandom_range(9) < 8) begin
          if (cmd == CMD_INSERT) begin
            pos = PosW'($urandom_range(held_len + 1, 1));
          end else begin
            pos = (held_len == 0) ? PosW'(1) : PosW'($urandom_range(held_len, 1));
          end
        end else begin
          pos = PosW'($urandom_range(31));
        end
        case ($urandom_range(7))
          0: word = 32'h8000_0000;
          1: word = 32'h7FFF_FFFF;
          default: word = $urandom;
        endcase
        send_word(draw_gap(idle_pcts[ph]), cmd, pos, word, 0, no_reply);
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (EndPause) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
